// ===== rtl/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Shared widths, byte patterns, code point limits and the result record.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam int BYTE_W   = 8;
	localparam int CP_W     = 21;
	localparam int TDATA_W  = 24;   // code point padded to whole bytes
	localparam int TUSER_W  = 3;
	localparam int REM_W    = 2;

	// Lead byte classification: (byte & mask) == pattern.
	localparam logic [BYTE_W-1:0] LEAD1_MASK = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD1_PAT  = 8'h00;
	localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
	localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

	localparam logic [CP_W-1:0] SURR_LO     = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI     = 21'h00DFFF;
	localparam logic [CP_W-1:0] SUPP_BASE   = 21'h010000;
	localparam logic [15:0]     HI_SURR_OFS = 16'hD800;
	localparam logic [15:0]     LO_SURR_OFS = 16'hDC00;

	localparam logic [REM_W-1:0] REM_NONE = 2'd0;
	localparam logic [REM_W-1:0] REM_ONE  = 2'd1;
	localparam logic [REM_W-1:0] REM_TWO  = 2'd2;
	localparam logic [REM_W-1:0] REM_THREE = 2'd3;

	typedef struct packed {
		logic [CP_W-1:0] code_unit;
		logic            unit_valid;
		logic            run_last;
		logic            string_done;
		logic            halted;
	} result_t;

endpackage

// ===== rtl/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 / UTF-32 stream transcoder
// Decodes one UTF-8 byte per transaction and emits UTF-16 units or code points.
// ----------------------------------------------------------------------------
// Path: an accepted byte is held in the input register, then its results move
// into the result register, whose entry 0 is presented on the master side.
// Throughput: one byte per cycle while the master side is ready; a byte that yields
// a surrogate pair holds the input stage while the two-entry result register drains.
// Reset: arst_n clears the decoder state, the input valid flag and the result count
// at once and sets the mode register to UTF-16; s_axis_tready is high out of reset.
module utf8_to_utf16_transcoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration: bit 0 selects UTF-16 (1) or whole code points (0).
	input  logic                            cfg_we,
	input  logic                            cfg_wdata,
	// Slave side. tdata: data_byte[7:0]. tlast: string_end.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [u8u16_pkg::BYTE_W-1:0]    s_axis_tdata,
	input  logic                            s_axis_tlast,
	// Master side. tdata: code_unit[20:0], zero padding[23:21].
	// tuser: unit_valid[0], string_done[1], halted[2]. tlast: run_last.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [u8u16_pkg::TDATA_W-1:0]   m_axis_tdata,
	output logic [u8u16_pkg::TUSER_W-1:0]   m_axis_tuser,
	output logic                            m_axis_tlast
);
	import u8u16_pkg::*;

	// Mode register.
	logic utf16_mode_q;

	// Input register stage.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// Decoder state carried between bytes.
	logic [REM_W-1:0] rem_q;
	logic [CP_W-1:0]  partial_q;
	logic             stopped_q;

	// Result register: up to two pending results, entry 0 is presented.
	logic [1:0] out_cnt_q;
	result_t    ent0_q;
	result_t    ent1_q;

	logic slot_free;
	logic advance;
	logic m_fire;
	logic s_fire;

	// Decode outputs.
	logic [REM_W-1:0] rem_d;
	logic [CP_W-1:0]  partial_d;
	logic             stopped_d;
	logic [1:0]       nres;
	result_t          res0;
	result_t          res1;

	logic             complete;
	logic             halt_now;
	logic [CP_W-1:0]  gathered;
	logic [CP_W-1:0]  cp;
	logic [CP_W-1:0]  supp;
	logic             single_unit;
	logic [15:0]      hi_unit;
	logic [15:0]      lo_unit;

	// Handshake. The input stage moves into the result register whenever the
	// register is empty or its last pending result leaves in this cycle.
	assign m_fire        = m_axis_tvalid && m_axis_tready;
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign slot_free     = (out_cnt_q == 2'd0) || ((out_cnt_q == 2'd1) && m_fire);
	assign advance       = valid_s1 && slot_free;
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = (out_cnt_q != 2'd0);
	assign m_axis_tdata  = {{(TDATA_W-CP_W){1'b0}}, ent0_q.code_unit};
	assign m_axis_tuser  = {ent0_q.halted, ent0_q.string_done, ent0_q.unit_valid};
	assign m_axis_tlast  = ent0_q.run_last;

	// Byte decoder. Continuation bytes contribute their low six bits without
	// any check; a lead byte fixes how many continuations follow.
	always_comb begin
		gathered  = {partial_q[CP_W-7:0], byte_s1[5:0]};
		complete  = 1'b0;
		halt_now  = 1'b0;
		rem_d     = rem_q;
		partial_d = partial_q;
		stopped_d = stopped_q;

		priority if (stopped_q) begin
			// Conversion halted: byte dropped.
		end else if (rem_q != REM_NONE) begin
			partial_d = gathered;
			rem_d     = rem_q - REM_ONE;
			complete  = (rem_q == REM_ONE);
		end else if ((byte_s1 & LEAD1_MASK) == LEAD1_PAT) begin
			partial_d = {{(CP_W-7){1'b0}}, byte_s1[6:0]};
			complete  = 1'b1;
		end else if ((byte_s1 & LEAD2_MASK) == LEAD2_PAT) begin
			partial_d = {{(CP_W-5){1'b0}}, byte_s1[4:0]};
			rem_d     = REM_ONE;
		end else if ((byte_s1 & LEAD3_MASK) == LEAD3_PAT) begin
			partial_d = {{(CP_W-4){1'b0}}, byte_s1[3:0]};
			rem_d     = REM_TWO;
		end else if ((byte_s1 & LEAD4_MASK) == LEAD4_PAT) begin
			partial_d = {{(CP_W-3){1'b0}}, byte_s1[2:0]};
			rem_d     = REM_THREE;
		end else begin
			halt_now = 1'b1;
		end

		// A sequence still open at the end of the string is truncated.
		if (!stopped_q && !complete && !halt_now && last_s1 && (rem_d != REM_NONE)) begin
			halt_now = 1'b1;
		end
		if (halt_now) begin
			stopped_d = 1'b1;
			rem_d     = REM_NONE;
			partial_d = '0;
		end

		// Encoding of a completed code point.
		cp          = partial_d;
		supp        = cp - SUPP_BASE;
		single_unit = !utf16_mode_q || (cp < SURR_LO) || ((cp > SURR_HI) && (cp < SUPP_BASE));
		hi_unit     = HI_SURR_OFS + {6'd0, supp[19:10]};
		lo_unit     = LO_SURR_OFS + {6'd0, supp[9:0]};

		res0 = '0;
		res1 = '0;
		nres = 2'd0;
		if (complete) begin
			res0.unit_valid  = 1'b1;
			res0.string_done = last_s1;
			if (single_unit) begin
				res0.code_unit = utf16_mode_q ? {5'd0, cp[15:0]} : cp;
				res0.run_last  = 1'b1;
				nres           = 2'd1;
			end else begin
				res0.code_unit   = {5'd0, hi_unit};
				res1.code_unit   = {5'd0, lo_unit};
				res1.unit_valid  = 1'b1;
				res1.run_last    = 1'b1;
				res1.string_done = last_s1;
				nres             = 2'd2;
			end
			partial_d = '0;
		end else if (halt_now || last_s1) begin
			// Status-only result: a halt or the end of a string.
			res0.run_last    = 1'b1;
			res0.string_done = last_s1;
			res0.halted      = stopped_d;
			nres             = 2'd1;
		end

		// Everything clears after the final byte of a string.
		if (last_s1) begin
			rem_d     = REM_NONE;
			partial_d = '0;
			stopped_d = 1'b0;
		end
	end

	// Control and decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_mode_q <= 1'b1;
			valid_s1     <= 1'b0;
			rem_q        <= REM_NONE;
			partial_q    <= '0;
			stopped_q    <= 1'b0;
			out_cnt_q    <= 2'd0;
		end else begin
			if (cfg_we) begin
				utf16_mode_q <= cfg_wdata;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				rem_q     <= rem_d;
				partial_q <= partial_d;
				stopped_q <= stopped_d;
				out_cnt_q <= nres;
			end else if (m_fire) begin
				out_cnt_q <= out_cnt_q - 2'd1;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (advance) begin
			ent0_q <= res0;
			ent1_q <= res1;
		end else if (m_fire && (out_cnt_q == 2'd2)) begin
			ent0_q <= ent1_q;
		end
	end

	// A result that carries a unit never reports a halt.
	a_valid_not_halted: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[2])
		else $error("unit result flagged as halted");

	// A status-only result carries a zero code unit.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
		else $error("status result with nonzero code unit");

	// The first half of a pending pair is never the end of its run.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q == 2'd2) |-> !ent0_q.run_last && ent1_q.run_last)
		else $error("surrogate pair out of order");

	// Decoder state is clean after the final byte of a string.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> (rem_q == REM_NONE) && !stopped_q && (partial_q == '0))
		else $error("state not cleared at end of string");

endmodule
